[rtl/baws_pkg.sv]
// Package for the bracket aware word splitter.
// Holds sizes, byte codes, nesting codes and the structs shared between the modules.
// No dependencies.
`default_nettype none

package baws_pkg;

    // Nesting stack size and level counter width (level runs 0..STACK_DEPTH)
    localparam int STACK_DEPTH = 16;
    localparam int LEVEL_W     = $clog2(STACK_DEPTH + 1);

    // Output queue: room for two results per input word plus slack
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // Word counter
    localparam logic [15:0] WORDS_MAX = 16'hFFFF;

    // Bytes of interest
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_NUL    = 8'h00;

    // Codes held on the nesting stack
    typedef logic [2:0] code_t;
    localparam code_t CODE_PAREN  = 3'd1;
    localparam code_t CODE_BRACE  = 3'd2;
    localparam code_t CODE_BRACK  = 3'd3;
    localparam code_t CODE_SQUOTE = 3'd4;
    localparam code_t CODE_DQUOTE = 3'd5;
    localparam code_t CODE_NONE   = 3'd0;

    // Command to the stack
    typedef struct packed {
        logic  push;
        logic  pop;
        logic  clear;
        code_t code;
    } stack_cmd_t;

    // Status from the stack
    typedef struct packed {
        code_t top;
        logic  empty;
        logic  full;
    } stack_stat_t;

    // One result word
    typedef struct packed {
        logic [7:0]  out_char;
        logic        has_char;
        logic        is_sep;
        logic [15:0] word_count;
        logic        overflow;
        logic        eos;
    } result_t;

    typedef logic [FIFO_CNT_W-1:0] fifo_cnt_t;

endpackage

`default_nettype wire

[rtl/baws_cell.sv]
// One cell of the nesting stack chain.
// Holds one code; shifts in from the neighbor above on push, below on pop.
// Depends on baws_pkg.
`default_nettype none

module baws_cell (
    input  wire logic           clk,
    input  wire logic           shift_dn,
    input  wire logic           shift_up,
    input  wire baws_pkg::code_t above,
    input  wire baws_pkg::code_t below,
    output baws_pkg::code_t     q
);

    baws_pkg::code_t code_reg;
    baws_pkg::code_t code_next;

    // Pick neighbor data
    always_comb
    begin
        code_next = code_reg;
        if (shift_dn)
        begin
            code_next = above;
        end
        else if (shift_up)
        begin
            code_next = below;
        end
    end

    // Payload only, no reset
    always_ff @(posedge clk)
    begin
        code_reg <= code_next;
    end

    assign q = code_reg;

endmodule

`default_nettype wire

[rtl/baws_stack.sv]
// Nesting stack built as a chain of cells, top of stack in cell 0.
// Keeps the level counter and reports top, empty and full.
// Depends on baws_pkg and baws_cell.
`default_nettype none

module baws_stack (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire baws_pkg::stack_cmd_t cmd,
    output baws_pkg::stack_stat_t    stat
);

    logic [baws_pkg::LEVEL_W-1:0] level_reg;
    logic [baws_pkg::LEVEL_W-1:0] level_next;
    logic                         full;
    logic                         empty;
    logic                         shift_dn;
    logic                         shift_up;
    baws_pkg::code_t              cell_q [baws_pkg::STACK_DEPTH];

    assign full     = (level_reg == baws_pkg::LEVEL_W'(baws_pkg::STACK_DEPTH));
    assign empty    = (level_reg == '0);
    assign shift_dn = cmd.push && !full && !cmd.clear;
    assign shift_up = cmd.pop && !cmd.clear;

    // Cell chain
    for (genvar i = 0; i < baws_pkg::STACK_DEPTH; i++)
    begin : g_cell
        baws_pkg::code_t above;
        baws_pkg::code_t below;
        if (i == 0)
        begin : g_top
            assign above = cmd.code;
        end
        else
        begin : g_mid
            assign above = cell_q[i-1];
        end
        if (i == baws_pkg::STACK_DEPTH - 1)
        begin : g_bot
            assign below = cell_q[i];
        end
        else
        begin : g_nbot
            assign below = cell_q[i+1];
        end
        baws_cell u_cell (
            .clk      (clk),
            .shift_dn (shift_dn),
            .shift_up (shift_up),
            .above    (above),
            .below    (below),
            .q        (cell_q[i])
        );
    end

    // Level counter
    always_comb
    begin
        level_next = level_reg;
        if (cmd.clear)
        begin
            level_next = '0;
        end
        else if (shift_dn)
        begin
            level_next = level_reg + baws_pkg::LEVEL_W'(1);
        end
        else if (shift_up && !empty)
        begin
            level_next = level_reg - baws_pkg::LEVEL_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= '0;
        end
        else
        begin
            level_reg <= level_next;
        end
    end

    assign stat.top   = cell_q[0];
    assign stat.empty = empty;
    assign stat.full  = full;

`ifndef SYNTH
    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        level_reg <= baws_pkg::LEVEL_W'(baws_pkg::STACK_DEPTH))
        else $error("stack level beyond depth");

    a_full_push_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.push && full && !cmd.clear) |=> (level_reg == $past(level_reg)))
        else $error("push onto full stack changed level");
`endif

endmodule

`default_nettype wire

[rtl/baws_fifo.sv]
// Small output queue of result words; takes up to two words per cycle.
// Register array, one read port at the head.
// Depends on baws_pkg.
`default_nettype none

module baws_fifo (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [1:0]        wr_cnt,
    input  wire baws_pkg::result_t wr_a,
    input  wire baws_pkg::result_t wr_b,
    input  wire logic              rd,
    output baws_pkg::result_t      rd_data,
    output logic                   rd_valid,
    output logic                   room2
);

    baws_pkg::result_t                mem [baws_pkg::FIFO_DEPTH];
    logic [baws_pkg::FIFO_PTR_W-1:0]  head_reg;
    logic [baws_pkg::FIFO_PTR_W-1:0]  head_next;
    logic [baws_pkg::FIFO_PTR_W-1:0]  tail_reg;
    logic [baws_pkg::FIFO_PTR_W-1:0]  tail_next;
    logic [baws_pkg::FIFO_PTR_W-1:0]  tail_p1;
    baws_pkg::fifo_cnt_t              count_reg;
    baws_pkg::fifo_cnt_t              count_next;
    logic                             do_rd;

    assign do_rd    = rd && (count_reg != '0);
    assign tail_p1  = tail_reg + baws_pkg::FIFO_PTR_W'(1);
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem[head_reg];
    assign room2    = (count_reg <= baws_pkg::FIFO_CNT_W'(baws_pkg::FIFO_DEPTH - 2));

    // Pointer and count update
    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg + baws_pkg::FIFO_PTR_W'(wr_cnt);
        count_next = count_reg + baws_pkg::FIFO_CNT_W'(wr_cnt);
        if (do_rd)
        begin
            head_next  = head_reg + baws_pkg::FIFO_PTR_W'(1);
            count_next = count_next - baws_pkg::FIFO_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (wr_cnt != 2'd0)
        begin
            mem[tail_reg] <= wr_a;
        end
        if (wr_cnt == 2'd2)
        begin
            mem[tail_p1] <= wr_b;
        end
    end

`ifndef SYNTH
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= baws_pkg::FIFO_CNT_W'(baws_pkg::FIFO_DEPTH))
        else $error("queue count beyond depth");

    a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_cnt != 2'd0) |-> room2)
        else $error("queue written without room");
`endif

endmodule

`default_nettype wire

[rtl/bracket_aware_word_splitter.sv]
// A result word enters the output queue when its input word is taken; the output shows the queue head.
// Throughput: one input word per cycle; a word that yields two results
// (held space then the byte) writes both, and the single output port shows them in turn.
// The input stalls only while the 4-entry output queue has fewer than two free slots.
// Reset (rst_n low, async): stack empty, word count 1, all flags and the queue cleared.
// Stack entries themselves are not reset; only entries below the level are read.
`default_nettype none

module bracket_aware_word_splitter (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] ch
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [7:0] out_char, [23:8] word_count, [24] overflow
    output logic [1:0]       m_tuser,   // [0] has_char, [1] is_separator
    output logic             m_tlast
);

    logic        space_pending_reg;
    logic        space_pending_next;
    logic        escape_pending_reg;
    logic        escape_pending_next;
    logic        seen_text_reg;
    logic        seen_text_next;
    logic [15:0] words_reg;
    logic [15:0] words_next;
    logic        overflow_reg;
    logic        overflow_next;

    logic                  acc;
    logic                  room2;
    baws_pkg::stack_cmd_t  cmd;
    baws_pkg::stack_stat_t stat;
    logic [1:0]            wr_cnt;
    baws_pkg::result_t     res_a;
    baws_pkg::result_t     res_b;
    baws_pkg::result_t     head;

    assign s_tready = room2;
    assign acc      = s_tvalid && room2;

    baws_stack u_stack (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .stat  (stat)
    );

    // Per-byte decode, stack command and result build
    always_comb
    begin
        logic              flush;
        logic              emit_ch;
        logic [15:0]       words_f;
        logic              ovf_new;
        baws_pkg::code_t   qcode;
        baws_pkg::result_t r_flush;
        baws_pkg::result_t r_char;
        baws_pkg::result_t r_bare;

        flush   = 1'b0;
        emit_ch = 1'b0;
        qcode   = baws_pkg::CODE_NONE;
        cmd     = '0;

        space_pending_next  = space_pending_reg;
        escape_pending_next = escape_pending_reg;
        seen_text_next      = seen_text_reg;

        if (escape_pending_reg)
        begin
            escape_pending_next = 1'b0;
            seen_text_next      = 1'b1;
            emit_ch             = 1'b1;
        end
        else if (s_tdata == baws_pkg::CH_SPACE)
        begin
            if (seen_text_reg)
            begin
                space_pending_next = 1'b1;
            end
        end
        else if (s_tdata == baws_pkg::CH_BSLASH)
        begin
            flush               = space_pending_reg;
            seen_text_next      = 1'b1;
            escape_pending_next = 1'b1;
        end
        else
        begin
            flush          = space_pending_reg;
            seen_text_next = 1'b1;
            emit_ch        = 1'b1;
            // Nesting tracking
            case (s_tdata)
                baws_pkg::CH_LPAREN:
                begin
                    cmd.push = 1'b1;
                    cmd.code = baws_pkg::CODE_PAREN;
                end
                baws_pkg::CH_LBRACE:
                begin
                    cmd.push = 1'b1;
                    cmd.code = baws_pkg::CODE_BRACE;
                end
                baws_pkg::CH_LBRACK:
                begin
                    cmd.push = 1'b1;
                    cmd.code = baws_pkg::CODE_BRACK;
                end
                baws_pkg::CH_RPAREN, baws_pkg::CH_RBRACE, baws_pkg::CH_RBRACK:
                begin
                    cmd.pop = !stat.empty;
                end
                baws_pkg::CH_SQUOTE, baws_pkg::CH_DQUOTE:
                begin
                    qcode = (s_tdata == baws_pkg::CH_SQUOTE) ? baws_pkg::CODE_SQUOTE
                                                             : baws_pkg::CODE_DQUOTE;
                    if (!stat.empty && stat.top == qcode)
                    begin
                        cmd.pop = 1'b1;
                    end
                    else
                    begin
                        cmd.push = 1'b1;
                        cmd.code = qcode;
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (flush)
        begin
            space_pending_next = 1'b0;
        end

        // Word count after a held space turns into a separator
        words_f = words_reg;
        if (flush && stat.empty && words_reg != baws_pkg::WORDS_MAX)
        begin
            words_f = words_reg + 16'd1;
        end
        ovf_new = overflow_reg || (cmd.push && stat.full);

        r_flush.out_char   = stat.empty ? baws_pkg::CH_NUL : baws_pkg::CH_SPACE;
        r_flush.has_char   = 1'b1;
        r_flush.is_sep     = stat.empty;
        r_flush.word_count = words_f;
        r_flush.overflow   = overflow_reg;
        r_flush.eos        = 1'b0;

        r_char.out_char    = s_tdata;
        r_char.has_char    = 1'b1;
        r_char.is_sep      = 1'b0;
        r_char.word_count  = words_f;
        r_char.overflow    = ovf_new;
        r_char.eos         = 1'b0;

        r_bare.out_char    = baws_pkg::CH_NUL;
        r_bare.has_char    = 1'b0;
        r_bare.is_sep      = 1'b0;
        r_bare.word_count  = words_f;
        r_bare.overflow    = ovf_new;
        r_bare.eos         = 1'b0;

        // Order results for the queue
        res_b  = r_char;
        wr_cnt = 2'd0;
        if (flush)
        begin
            res_a  = r_flush;
            wr_cnt = emit_ch ? 2'd2 : 2'd1;
        end
        else if (emit_ch)
        begin
            res_a  = r_char;
            wr_cnt = 2'd1;
        end
        else
        begin
            res_a  = r_bare;
            wr_cnt = s_tlast ? 2'd1 : 2'd0;
        end
        if (wr_cnt == 2'd2)
        begin
            res_b.eos = s_tlast;
        end
        else
        begin
            res_a.eos = s_tlast;
        end

        words_next    = words_f;
        overflow_next = ovf_new;

        // End of string restores the reset state
        if (s_tlast)
        begin
            space_pending_next  = 1'b0;
            escape_pending_next = 1'b0;
            seen_text_next      = 1'b0;
            words_next          = 16'd1;
            overflow_next       = 1'b0;
            cmd.clear           = 1'b1;
        end

        // Nothing moves without an accepted word
        if (!acc)
        begin
            cmd                 = '0;
            wr_cnt              = 2'd0;
            space_pending_next  = space_pending_reg;
            escape_pending_next = escape_pending_reg;
            seen_text_next      = seen_text_reg;
            words_next          = words_reg;
            overflow_next       = overflow_reg;
        end
    end

    // String state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            space_pending_reg  <= 1'b0;
            escape_pending_reg <= 1'b0;
            seen_text_reg      <= 1'b0;
            words_reg          <= 16'd1;
            overflow_reg       <= 1'b0;
        end
        else
        begin
            space_pending_reg  <= space_pending_next;
            escape_pending_reg <= escape_pending_next;
            seen_text_reg      <= seen_text_next;
            words_reg          <= words_next;
            overflow_reg       <= overflow_next;
        end
    end

    baws_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_cnt   (wr_cnt),
        .wr_a     (res_a),
        .wr_b     (res_b),
        .rd       (m_tready),
        .rd_data  (head),
        .rd_valid (m_tvalid),
        .room2    (room2)
    );

    // Output packing
    assign m_tdata = {7'd0, head.overflow, head.word_count, head.out_char};
    assign m_tuser = {head.is_sep, head.has_char};
    assign m_tlast = head.eos;

`ifndef SYNTH
    a_eos_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && s_tlast) |=> (words_reg == 16'd1 && !seen_text_reg && !space_pending_reg))
        else $error("string state not cleared after last word");

    a_words_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        words_reg != 16'd0)
        else $error("word count reached zero");
`endif

endmodule

`default_nettype wire
